### rtl/core/plcd_pkg.sv
package plcd_pkg;

    localparam int COORD_W = 16;

    typedef logic [COORD_W-1:0] t_coord;

    // one sampled level of the display bus
    typedef struct packed {
        logic       wr_strobe;
        logic [7:0] data_byte;
        logic       is_data;
        logic       select_n;
        logic       reset_n;
    } t_in_word;

    typedef struct packed {
        logic       kind;
        t_coord     pix_x;
        t_coord     pix_y;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       frame_done;
    } t_out_word;

    // result of one bus word, from the command machine to the output register
    typedef struct packed {
        logic      valid;
        t_out_word word;
    } t_res;

    localparam logic KIND_PIXEL   = 1'b0;
    localparam logic KIND_FMT_ERR = 1'b1;

    localparam logic [7:0] CMD_YWIN   = 8'h2A;
    localparam logic [7:0] CMD_XWIN   = 8'h2B;
    localparam logic [7:0] CMD_RAMWR  = 8'h2C;
    localparam logic [7:0] CMD_PIXFMT = 8'h3A;
    localparam logic [7:0] CMD_MADCTL = 8'h36;

    localparam logic [7:0] PIXFMT_RGB565 = 8'h55;
    localparam int         MADCTL_ROW_BIT = 5;

endpackage

### rtl/core/plcd_in_if.sv
interface plcd_in_if;
    import plcd_pkg::*;

    logic     valid;
    logic     ready;
    t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/plcd_out_if.sv
interface plcd_out_if;
    import plcd_pkg::*;

    logic      valid;
    logic      ready;
    t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/plcd_step.sv
// Cursor stepper: inner coordinate a, then outer coordinate b on a wrap of a.
module plcd_step (
    input  plcd_pkg::t_coord i_a,
    input  plcd_pkg::t_coord i_a_lo,
    input  plcd_pkg::t_coord i_a_hi,
    input  plcd_pkg::t_coord i_b,
    input  plcd_pkg::t_coord i_b_lo,
    input  plcd_pkg::t_coord i_b_hi,
    output plcd_pkg::t_coord o_a_next,
    output plcd_pkg::t_coord o_b_next,
    output logic             o_wrap
);
    import plcd_pkg::*;

    logic [COORD_W:0] a_inc;
    logic [COORD_W:0] b_inc;
    logic             a_fits;
    logic             b_fits;

    // compare one bit wider so a cursor at all ones always wraps
    always_comb begin
        a_inc  = {1'b0, i_a} + {{COORD_W{1'b0}}, 1'b1};
        b_inc  = {1'b0, i_b} + {{COORD_W{1'b0}}, 1'b1};
        a_fits = a_inc <= {1'b0, i_a_hi};
        b_fits = b_inc <= {1'b0, i_b_hi};
    end

    assign o_a_next = a_fits ? a_inc[COORD_W-1:0] : i_a_lo;
    assign o_b_next = a_fits ? i_b : (b_fits ? b_inc[COORD_W-1:0] : i_b_lo);
    assign o_wrap   = !a_fits && !b_fits;

endmodule

### rtl/core/plcd_core.sv
// Command machine: strobe edge detect, window/mode registers, pixel assembly.
module plcd_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  plcd_pkg::t_in_word i_word,
    output plcd_pkg::t_res     o_res
);
    import plcd_pkg::*;

    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_YWIN   = 3'd1;
    localparam logic [2:0] PH_XWIN   = 3'd2;
    localparam logic [2:0] PH_RAM    = 3'd3;
    localparam logic [2:0] PH_MODE   = 3'd4;
    localparam logic [2:0] PH_MADCTL = 3'd5;

    logic       r_prev_strobe, n_prev_strobe;
    logic [2:0] r_phase,       n_phase;
    logic [1:0] r_byte_step,   n_byte_step;
    t_coord     r_win_ys,      n_win_ys;
    t_coord     r_win_ye,      n_win_ye;
    t_coord     r_win_xs,      n_win_xs;
    t_coord     r_win_xe,      n_win_xe;
    t_coord     r_cur_x,       n_cur_x;
    t_coord     r_cur_y,       n_cur_y;
    logic       r_row_major,   n_row_major;
    logic [7:0] r_first_byte,  n_first_byte;

    logic       byte_take;
    logic [7:0] b;
    t_coord     step_a;
    t_coord     step_b;
    t_coord     a_next;
    t_coord     b_next;
    logic       wrap;
    t_coord     load_start;
    t_coord     load_end;

    function automatic logic [2:0] cmd_phase(input logic [7:0] cmd, input logic [2:0] cur);
        logic [2:0] ph;
        begin
            unique case (cmd)
                CMD_YWIN:   ph = PH_YWIN;
                CMD_XWIN:   ph = PH_XWIN;
                CMD_RAMWR:  ph = PH_RAM;
                CMD_PIXFMT: ph = PH_MODE;
                CMD_MADCTL: ph = PH_MADCTL;
                default:    ph = cur;
            endcase
            return ph;
        end
    endfunction

    // column-major: y inner, x outer; row-major swaps the cursors, windows stay
    assign step_a = r_row_major ? r_cur_x : r_cur_y;
    assign step_b = r_row_major ? r_cur_y : r_cur_x;

    plcd_step u_step (
        .i_a      (step_a),
        .i_a_lo   (r_win_ys),
        .i_a_hi   (r_win_ye),
        .i_b      (step_b),
        .i_b_lo   (r_win_xs),
        .i_b_hi   (r_win_xe),
        .o_a_next (a_next),
        .o_b_next (b_next),
        .o_wrap   (wrap)
    );

    assign b         = i_word.data_byte;
    assign byte_take = i_word.reset_n && !i_word.select_n && !i_word.wr_strobe && r_prev_strobe;

    // result is computed from the held word and the current state; state moves only when it advances
    always_comb begin
        n_prev_strobe = r_prev_strobe;
        n_phase       = r_phase;
        n_byte_step   = r_byte_step;
        n_win_ys      = r_win_ys;
        n_win_ye      = r_win_ye;
        n_win_xs      = r_win_xs;
        n_win_xe      = r_win_xe;
        n_cur_x       = r_cur_x;
        n_cur_y       = r_cur_y;
        n_row_major   = r_row_major;
        n_first_byte  = r_first_byte;
        o_res         = '0;

        // window register pair being loaded (y or x)
        load_start = (r_phase == PH_YWIN) ? r_win_ys : r_win_xs;
        load_end   = (r_phase == PH_YWIN) ? r_win_ye : r_win_xe;

        if (byte_take) begin
            unique case (r_phase)
                PH_YWIN, PH_XWIN: begin
                    unique case (r_byte_step)
                        2'd0: load_start = {b, 8'h00};
                        2'd1: load_start = load_start | {8'h00, b};
                        2'd2: load_end   = {b, 8'h00};
                        default: begin
                            load_end = load_end | {8'h00, b};
                            n_phase  = PH_IDLE;
                        end
                    endcase
                    n_byte_step = r_byte_step + 2'd1;
                    if (r_phase == PH_YWIN) begin
                        n_win_ys = load_start;
                        n_win_ye = load_end;
                    end else begin
                        n_win_xs = load_start;
                        n_win_xe = load_end;
                    end
                end
                PH_RAM: begin
                    if (!i_word.is_data) begin
                        n_byte_step = 2'd0;
                        n_phase     = cmd_phase(b, r_phase);
                    end else if (r_byte_step == 2'd0 || r_byte_step == 2'd1) begin
                        // first data byte after the command reloads the cursor
                        if (r_byte_step == 2'd0) begin
                            n_cur_x = r_win_xs;
                            n_cur_y = r_win_ys;
                        end
                        n_first_byte = b;
                        n_byte_step  = 2'd2;
                    end else begin
                        o_res.valid           = 1'b1;
                        o_res.word.kind       = KIND_PIXEL;
                        o_res.word.pix_x      = r_cur_x;
                        o_res.word.pix_y      = r_cur_y;
                        o_res.word.red        = {b[4:0], 3'b000};
                        o_res.word.green      = {r_first_byte[2:0], b[7:5], 2'b00};
                        o_res.word.blue       = {r_first_byte[7:3], 3'b000};
                        o_res.word.frame_done = wrap;
                        n_byte_step           = 2'd1;
                        n_cur_x               = r_row_major ? a_next : b_next;
                        n_cur_y               = r_row_major ? b_next : a_next;
                    end
                end
                PH_MODE: begin
                    n_phase = PH_IDLE;
                    if (b != PIXFMT_RGB565) begin
                        o_res.valid     = 1'b1;
                        o_res.word.kind = KIND_FMT_ERR;
                    end
                end
                PH_MADCTL: begin
                    n_row_major = b[MADCTL_ROW_BIT];
                    n_phase     = PH_IDLE;
                end
                default: begin
                    n_byte_step = 2'd0;
                    n_phase     = i_word.is_data ? PH_IDLE : cmd_phase(b, PH_IDLE);
                end
            endcase
        end

        if (i_fire) begin
            n_prev_strobe = i_word.wr_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_strobe <= 1'b0;
            r_phase       <= PH_IDLE;
            r_byte_step   <= 2'd0;
            r_win_ys      <= '0;
            r_win_ye      <= '0;
            r_win_xs      <= '0;
            r_win_xe      <= '0;
            r_cur_x       <= '0;
            r_cur_y       <= '0;
            r_row_major   <= 1'b0;
            r_first_byte  <= 8'h00;
        end else if (i_fire) begin
            r_prev_strobe <= n_prev_strobe;
            r_phase       <= n_phase;
            r_byte_step   <= n_byte_step;
            r_win_ys      <= n_win_ys;
            r_win_ye      <= n_win_ye;
            r_win_xs      <= n_win_xs;
            r_win_xe      <= n_win_xe;
            r_cur_x       <= n_cur_x;
            r_cur_y       <= n_cur_y;
            r_row_major   <= n_row_major;
            r_first_byte  <= n_first_byte;
        end
    end

    // memory write only ever sees steps 0..2
    a_ram_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_RAM |-> r_byte_step != 2'd3)
        else $error("byte step out of range in memory write");

    // frame_done only on a pixel write
    a_done_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.word.frame_done |-> o_res.word.kind == KIND_PIXEL)
        else $error("frame_done on error word");

    // a taken mode byte always ends in idle
    a_madctl_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && byte_take && r_phase == PH_MADCTL |=> r_phase == PH_IDLE)
        else $error("mode byte did not return to idle");

endmodule

### rtl/core/parallel_lcd_rgb565_write_port.sv
// Channel | dir | word                                             | handshake
// i_in    | in  | wr_strobe, data_byte, is_data, select_n, reset_n | valid/ready
// o_out   | out | kind, pix_x, pix_y, red, green, blue, frame_done | valid/ready
//
// One bus sample per cycle sustained while the result register can take results;
// a word is held in the input register, then the command machine writes its
// result straight into the result register when the word advances.
// Reset (i_rst_n low, synchronous) empties both registers and clears the
// windows, cursor, mode and phase.
// A full, unread result register blocks only a pending word that makes a
// result; other words keep flowing past it.
module parallel_lcd_rgb565_write_port (
    input  logic             i_clk,
    input  logic             i_rst_n,
    plcd_in_if.sink          i_in,
    plcd_out_if.source       o_out
);
    import plcd_pkg::*;

    logic      r_in_valid;
    t_in_word  r_in_word;
    logic      r_out_valid;
    t_out_word r_out_word;

    logic      fire;
    t_res      res;

    // the held sample advances unless it makes a result that has nowhere to go
    assign fire       = r_in_valid && (!res.valid || !r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || fire;

    plcd_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_word  (r_in_word),
        .o_res   (res)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_word <= i_in.data;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && res.valid) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && res.valid) begin
            r_out_word <= res.word;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_word;

    // a held sample that did not advance is still there, unchanged
    a_hold_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !fire |=> r_in_valid && $stable(r_in_word))
        else $error("stalled sample lost");

    // an unread result is never overwritten
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_out.ready |-> !(fire && res.valid))
        else $error("result register overrun");

    // an unread result survives the stall
    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_out.ready |=> r_out_valid)
        else $error("unread result dropped");

endmodule

### verif/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import plcd_pkg::*;

    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int DRAIN_CYCLES    = 10;
    localparam int TOTAL_SAMPLES   = 840;
    localparam int ERROR_PRINT_MAX = 40;

    // command machine phases of the bus decoder
    typedef enum logic [2:0] {
        BUS_IDLE,
        BUS_YWIN,
        BUS_XWIN,
        BUS_RAMWR,
        BUS_PIXFMT,
        BUS_MADCTL
    } t_bus_phase;

    logic clk;
    logic rst_n;

    plcd_in_if  in_bus ();
    plcd_out_if out_bus ();

    parallel_lcd_rgb565_write_port u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    // shared knobs between the sender, the receiver and the test tasks
    bit no_gaps      = 1'b0;
    int hold_len     = 0;
    int samples_sent = 0;
    int errors       = 0;
    int idle_cycles  = 0;

    // predicted state of the bus decoder
    logic       last_strobe = 1'b0;
    t_bus_phase phase       = BUS_IDLE;
    logic [1:0] step        = '0;
    t_coord     win_y_lo    = '0;
    t_coord     win_y_hi    = '0;
    t_coord     win_x_lo    = '0;
    t_coord     win_x_hi    = '0;
    t_coord     cur_x       = '0;
    t_coord     cur_y       = '0;
    logic       row_major   = 1'b0;
    logic [7:0] first_byte  = '0;

    t_out_word exp_writes[$];

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic flag_error(input string msg);
        errors++;
        if (errors <= ERROR_PRINT_MAX) $display("ERROR @%0t: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want) flag_error($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic void decode_cmd(input logic [7:0] b);
        step = '0;
        case (b)
            CMD_YWIN:   phase = BUS_YWIN;
            CMD_XWIN:   phase = BUS_XWIN;
            CMD_RAMWR:  phase = BUS_RAMWR;
            CMD_PIXFMT: phase = BUS_PIXFMT;
            CMD_MADCTL: phase = BUS_MADCTL;
            default: ;
        endcase
    endfunction

    // start high, start low, end high, end low
    function automatic void load_window(inout t_coord lo, inout t_coord hi,
                                        input logic [7:0] b);
        case (step)
            2'd0: lo = {b, 8'h00};
            2'd1: lo = {lo[15:8], b};
            2'd2: hi = {b, 8'h00};
            default: begin
                hi    = {hi[15:8], b};
                phase = BUS_IDLE;
            end
        endcase
        step = step + 2'd1;
    endfunction

    // inner cursor first, then outer; compare is 17 bits so 0xFFFF always wraps
    function automatic logic step_cursor(inout t_coord a, input t_coord a_lo,
                                         input t_coord a_hi, inout t_coord c,
                                         input t_coord c_lo, input t_coord c_hi);
        logic [16:0] na;
        logic [16:0] nc;
        na = {1'b0, a} + 17'd1;
        if (na <= {1'b0, a_hi}) begin
            a = na[15:0];
            return 1'b0;
        end
        a  = a_lo;
        nc = {1'b0, c} + 17'd1;
        if (nc <= {1'b0, c_hi}) begin
            c = nc[15:0];
            return 1'b0;
        end
        c = c_lo;
        return 1'b1;
    endfunction

    function automatic void predict_sample(input t_in_word w);
        t_out_word res;
        logic      fell;
        fell        = w.reset_n && !w.select_n && !w.wr_strobe && last_strobe;
        last_strobe = w.wr_strobe;
        res         = '0;
        if (fell) begin
            case (phase)
                BUS_YWIN: load_window(win_y_lo, win_y_hi, w.data_byte);
                BUS_XWIN: load_window(win_x_lo, win_x_hi, w.data_byte);
                BUS_RAMWR: begin
                    if (!w.is_data) begin
                        decode_cmd(w.data_byte);
                    end else begin
                        // first data byte after a (re)start reloads the cursor
                        if (step == 2'd0) begin
                            cur_x = win_x_lo;
                            cur_y = win_y_lo;
                            step  = 2'd1;
                        end
                        if (step == 2'd1) begin
                            first_byte = w.data_byte;
                            step       = 2'd2;
                        end else begin
                            res.kind  = KIND_PIXEL;
                            res.pix_x = cur_x;
                            res.pix_y = cur_y;
                            res.red   = {w.data_byte[4:0], 3'b000};
                            res.green = {first_byte[2:0], w.data_byte[7:5], 2'b00};
                            res.blue  = {first_byte[7:3], 3'b000};
                            step      = 2'd1;
                            if (!row_major)
                                res.frame_done = step_cursor(cur_y, win_y_lo, win_y_hi,
                                                             cur_x, win_x_lo, win_x_hi);
                            else
                                res.frame_done = step_cursor(cur_x, win_y_lo, win_y_hi,
                                                             cur_y, win_x_lo, win_x_hi);
                            exp_writes.push_back(res);
                        end
                    end
                end
                BUS_PIXFMT: begin
                    phase = BUS_IDLE;
                    if (w.data_byte != PIXFMT_RGB565) begin
                        res.kind = KIND_FMT_ERR;
                        exp_writes.push_back(res);
                    end
                end
                BUS_MADCTL: begin
                    row_major = w.data_byte[MADCTL_ROW_BIT];
                    phase     = BUS_IDLE;
                end
                default: begin
                    phase = BUS_IDLE;
                    step  = '0;
                    if (!w.is_data) decode_cmd(w.data_byte);
                end
            endcase
        end
    endfunction

    // ------------------------------------------------------------------
    // Monitors: input words feed the predictor, results are checked in order
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n && in_bus.valid && in_bus.ready) predict_sample(in_bus.data);
    end

    always @(posedge clk) begin : result_check
        t_out_word want;
        if (rst_n && out_bus.valid && out_bus.ready) begin
            if (exp_writes.size() == 0) begin
                flag_error("result word with nothing expected");
            end else begin
                want = exp_writes.pop_front();
                check_field("kind", 16'(out_bus.data.kind), 16'(want.kind));
                check_field("pix_x", out_bus.data.pix_x, want.pix_x);
                check_field("pix_y", out_bus.data.pix_y, want.pix_y);
                check_field("red", 16'(out_bus.data.red), 16'(want.red));
                check_field("green", 16'(out_bus.data.green), 16'(want.green));
                check_field("blue", 16'(out_bus.data.blue), 16'(want.blue));
                check_field("frame_done", 16'(out_bus.data.frame_done),
                            16'(want.frame_done));
            end
        end
    end

    // counts cycles with no word moving on either side
    always @(posedge clk) begin
        if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no word moved for %0d cycles", idle_cycles);
                $display("testbench NOT OK");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender and receiver
    // ------------------------------------------------------------------
    // mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        if (no_gaps) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_in_word rand_sample();
        logic [31:0] raw;
        raw = $urandom;
        return raw[$bits(t_in_word)-1:0];
    endfunction

    task automatic send_sample(input t_in_word w);
        int gap;
        gap = pick_gap();
        if (gap != 0) begin
            in_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_bus.valid <= 1'b1;
        in_bus.data  <= w;
        @(posedge clk);
        while (!in_bus.ready) @(posedge clk);
        samples_sent++;
    endtask

    initial begin : receiver
        int n;
        out_bus.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (hold_len != 0) begin
                // long hold-off so the block fills and stalls its input
                n        = hold_len;
                hold_len = 0;
                out_bus.ready <= 1'b0;
                repeat (n) @(posedge clk);
            end else begin
                n = (no_gaps || $urandom_range(0, 3) != 0) ? 0 : pick_gap();
                if (n == 0) begin
                    out_bus.ready <= 1'b1;
                    @(posedge clk);
                end else begin
                    out_bus.ready <= 1'b0;
                    repeat (n) @(posedge clk);
                end
            end
        end
    end

    // one bus write: strobe high with junk on the other lines, then the falling sample
    task automatic bus_write(input logic dat, input logic [7:0] b, input logic sel_n,
                             input logic pin_rst_n);
        t_in_word w;
        w           = rand_sample();
        w.wr_strobe = 1'b1;
        send_sample(w);
        w.wr_strobe = 1'b0;
        w.data_byte = b;
        w.is_data   = dat;
        w.select_n  = sel_n;
        w.reset_n   = pin_rst_n;
        send_sample(w);
    endtask

    task automatic write_cmd(input logic [7:0] b);
        bus_write(1'b0, b, 1'b0, 1'b1);
    endtask

    task automatic write_data(input logic [7:0] b);
        bus_write(1'b1, b, 1'b0, 1'b1);
    endtask

    task automatic set_window(input logic [7:0] cmd, input t_coord lo, input t_coord hi,
                              input logic dat);
        write_cmd(cmd);
        bus_write(dat, lo[15:8], 1'b0, 1'b1);
        bus_write(dat, lo[7:0], 1'b0, 1'b1);
        bus_write(dat, hi[15:8], 1'b0, 1'b1);
        bus_write(dat, hi[7:0], 1'b0, 1'b1);
    endtask

    function automatic t_coord rand_coord();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7) return 16'($urandom_range(0, 5));
        if (r < 8) return 16'hFFFF - 16'($urandom_range(0, 3));
        return 16'($urandom_range(0, 16'hFFFF));
    endfunction

    // memory write of n bytes, sprinkled with gated writes and stray commands
    task automatic memory_burst(input int n);
        write_cmd(CMD_RAMWR);
        repeat (n) begin
            case ($urandom_range(0, 31))
                0: bus_write(1'b1, 8'($urandom_range(0, 255)), 1'b1, 1'b1);
                1: bus_write(1'b1, 8'($urandom_range(0, 255)), 1'b0, 1'b0);
                2: write_cmd(8'($urandom_range(0, 255)));
                3: send_sample(rand_sample());
                default: write_data(8'($urandom_range(0, 255)));
            endcase
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_basic_frame();
        set_window(CMD_YWIN, 16'h0000, 16'h0001, 1'b1);
        set_window(CMD_XWIN, 16'h0000, 16'h0001, 1'b1);
        write_cmd(CMD_MADCTL);
        write_data(8'h00);
        write_cmd(CMD_PIXFMT);
        write_data(PIXFMT_RGB565);
        write_cmd(CMD_RAMWR);
        // 2x2 window: fourth pixel closes the frame
        write_data(8'h00); write_data(8'h00);
        write_data(8'hFF); write_data(8'hFF);
        write_data(8'hF8); write_data(8'h1F);
        write_data(8'h07); write_data(8'hE0);
    endtask

    task automatic test_row_major();
        write_cmd(CMD_MADCTL);
        write_data(8'h20);
        write_cmd(CMD_RAMWR);
        repeat (3) begin
            write_data(8'hA5);
            write_data(8'h5A);
        end
        write_cmd(CMD_MADCTL);
        write_data(8'hDF);
    endtask

    task automatic test_pixel_format();
        write_cmd(CMD_PIXFMT);
        write_data(8'h00);
        write_cmd(CMD_PIXFMT);
        write_data(8'hFF);
        write_cmd(CMD_PIXFMT);
        write_data(PIXFMT_RGB565);
    endtask

    task automatic test_window_edges();
        // window bytes flagged as commands still load; cursor at 0xFFFF wraps
        set_window(CMD_YWIN, 16'hFFFF, 16'hFFFF, 1'b0);
        set_window(CMD_XWIN, 16'hFFFE, 16'hFFFF, 1'b0);
        write_cmd(CMD_RAMWR);
        repeat (3) begin
            write_data(8'hC3);
            write_data(8'h3C);
        end
        // empty window: wraps on every pixel
        set_window(CMD_YWIN, 16'h0005, 16'h0002, 1'b1);
        set_window(CMD_XWIN, 16'h0000, 16'h0000, 1'b1);
        write_cmd(CMD_RAMWR);
        repeat (2) begin
            write_data(8'h81);
            write_data(8'h18);
        end
    endtask

    task automatic test_commands_mid_write();
        set_window(CMD_YWIN, 16'h0000, 16'h0003, 1'b1);
        set_window(CMD_XWIN, 16'h0000, 16'h0003, 1'b1);
        write_cmd(CMD_RAMWR);
        write_data(8'h12); write_data(8'h34);
        write_data(8'h56);
        // unknown command drops the pending byte and restarts at the window origin
        write_cmd(8'h00);
        write_data(8'h78); write_data(8'h9A);
        write_data(8'h11);
        set_window(CMD_XWIN, 16'h0002, 16'h0003, 1'b1);
        // idle: data and unknown commands are ignored
        write_data(8'h22);
        write_cmd(8'hFF);
        write_cmd(CMD_RAMWR);
        write_data(8'h44); write_data(8'h66);
    endtask

    task automatic test_bus_gating();
        t_in_word w;
        write_cmd(CMD_RAMWR);
        write_data(8'hE7);
        bus_write(1'b1, 8'h33, 1'b1, 1'b1);   // deselected
        bus_write(1'b1, 8'h44, 1'b0, 1'b0);   // reset pin held low
        // strobe stays low: no falling edge
        w           = '0;
        w.data_byte = 8'h66;
        w.is_data   = 1'b1;
        w.reset_n   = 1'b1;
        send_sample(w);
        send_sample(w);
        // strobe held high over several samples, then falls
        w.wr_strobe = 1'b1;
        send_sample(w);
        send_sample(w);
        w.wr_strobe = 1'b0;
        w.data_byte = 8'h99;
        send_sample(w);
    endtask

    task automatic test_backpressure();
        set_window(CMD_YWIN, 16'h0000, 16'h0002, 1'b1);
        set_window(CMD_XWIN, 16'h0000, 16'h0002, 1'b1);
        hold_len = 400;
        no_gaps  = 1'b1;
        memory_burst(60);
        no_gaps  = 1'b0;
    endtask

    task automatic test_random_traffic();
        logic [7:0] b;
        while (samples_sent < TOTAL_SAMPLES) begin
            no_gaps = ($urandom_range(0, 7) == 0);
            case ($urandom_range(0, 9))
                0: set_window(CMD_YWIN, rand_coord(), rand_coord(),
                              1'($urandom_range(0, 1)));
                1: set_window(CMD_XWIN, rand_coord(), rand_coord(),
                              1'($urandom_range(0, 1)));
                2: begin
                    write_cmd(CMD_MADCTL);
                    bus_write(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                              1'b0, 1'b1);
                end
                3: begin
                    b = ($urandom_range(0, 1) != 0) ? PIXFMT_RGB565
                                                    : 8'($urandom_range(0, 255));
                    write_cmd(CMD_PIXFMT);
                    bus_write(1'($urandom_range(0, 1)), b, 1'b0, 1'b1);
                end
                4: repeat ($urandom_range(1, 6)) send_sample(rand_sample());
                default: memory_burst($urandom_range(1, 24));
            endcase
        end
        no_gaps = 1'b0;
    endtask

    initial begin
        rst_n        <= 1'b0;
        in_bus.valid <= 1'b0;
        in_bus.data  <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        test_basic_frame();
        test_row_major();
        test_pixel_format();
        test_window_edges();
        test_commands_mid_write();
        test_bus_gating();
        test_backpressure();
        test_random_traffic();

        in_bus.valid <= 1'b0;
        while (exp_writes.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (exp_writes.size() != 0)
            flag_error($sformatf("%0d result words never arrived", exp_writes.size()));

        if (errors == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule

### sim.f
rtl/core/plcd_pkg.sv
rtl/core/plcd_in_if.sv
rtl/core/plcd_out_if.sv
rtl/core/plcd_step.sv
rtl/core/plcd_core.sv
rtl/core/parallel_lcd_rgb565_write_port.sv
verif/testbench.sv
